// ===== src/scba_pkg.sv =====
// Shared types, constants and helper functions for the size-class block allocator.
package scba_pkg;

    // Geometry of the allocator: classes, smallest block and per-class region.
    localparam int NUM_CLASSES   = 5;
    localparam int LOG_MIN_BLOCK = 4;
    localparam int LOG_POOL      = 10;
    localparam int MAX_PER_CLASS = 1 << (LOG_POOL - LOG_MIN_BLOCK);
    localparam int LINK_DEPTH    = NUM_CLASSES * MAX_PER_CLASS;

    // Field and storage widths.
    localparam int CMD_W   = 1;
    localparam int SIZE_W  = 16;
    localparam int ADDR_W  = 13;
    localparam int STAT_W  = 3;
    localparam int CLS_W   = 3;
    localparam int BYTES_W = 9;
    localparam int TOTAL_W = 32;
    localparam int IDX_W   = LOG_POOL - LOG_MIN_BLOCK;
    localparam int HEAD_W  = IDX_W + 1;
    localparam int LINK_AW = CLS_W + IDX_W;

    // Marker for an empty free list.
    localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(MAX_PER_CLASS);

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STAT_W-1:0] ST_LARGE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OOM     = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADADDR = 3'd4;

    // Input request payload.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  block_addr;
        logic [CLS_W-1:0]   size_class;
        logic [BYTES_W-1:0] block_bytes;
        logic [TOTAL_W-1:0] allocated_total;
        logic [TOTAL_W-1:0] freed_total;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    // Block size in bytes of a class.
    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        return (BYTES_W'(1) << LOG_MIN_BLOCK) << c;
    endfunction

    // Number of blocks in a class region.
    function automatic logic [HEAD_W-1:0] class_blocks(input int c);
        return HEAD_W'(MAX_PER_CLASS >> c);
    endfunction

endpackage

// ===== src/scba_ctrl.sv =====
// Controller state machine: request handshake, sequencing and result valid.
module scba_ctrl
    import scba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   w_accept;

    // A request is taken in idle once the result register is free or drains now.
    assign o_req_ready   = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign w_accept      = i_req_valid && o_req_ready;
    assign o_cmd.capture = w_accept;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_rsp_valid   = r_rsp_valid;

    // Next state and next result-valid.
    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_rsp_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

// ===== src/scba_datapath.sv =====
// Datapath: request decode, free lists, link memory, carving counts and totals.
module scba_datapath
    import scba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req,
    output t_rsp    o_rsp
);

    // Free list state.
    logic [HEAD_W-1:0]  r_heads [NUM_CLASSES];
    logic [HEAD_W-1:0]  r_fresh [NUM_CLASSES];
    logic [TOTAL_W-1:0] r_alloc_total;
    logic [TOTAL_W-1:0] r_freed_total;
    logic [HEAD_W-1:0]  r_link_mem [LINK_DEPTH];
    logic [HEAD_W-1:0]  r_link_rd;

    // Captured request.
    logic [CMD_W-1:0]  r_op;
    logic [STAT_W-1:0] r_pre_st;
    logic [CLS_W-1:0]  r_cls;
    logic [IDX_W-1:0]  r_fidx;
    logic [ADDR_W-1:0] r_faddr;
    t_rsp              r_rsp;

    // Decode signals.
    logic [CLS_W-1:0]    a_cls;
    logic [HEAD_W-1:0]   a_head;
    logic [LINK_AW-1:0]  a_rd_addr;
    logic [CLS_W-1:0]    f_cls;
    logic [LOG_POOL-1:0] f_off;
    logic [CLS_W:0]      f_shift;
    logic [LOG_POOL-1:0] f_mask;
    logic                f_bad;
    logic [STAT_W-1:0]   d_pre_st;

    // Execute signals.
    logic [HEAD_W-1:0]  e_head;
    logic [HEAD_W-1:0]  e_fresh;
    logic [HEAD_W-1:0]  e_fresh_dec;
    logic [BYTES_W-1:0] e_bytes;
    logic [CLS_W:0]     e_shift;
    logic [IDX_W-1:0]   e_idx;
    logic               e_pop;
    logic               e_carve;
    logic               e_push;
    t_rsp               n_rsp;

    // Smallest class whose block holds the requested size.
    always_comb begin
        a_cls = CLS_W'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
            if (SIZE_W'(class_bytes(CLS_W'(c))) >= i_req.req_size) begin
                a_cls = CLS_W'(c);
            end
        end
    end

    assign a_head    = r_heads[a_cls];
    assign a_rd_addr = {a_cls, a_head[IDX_W-1:0]};

    // Free address decode: region gives the class, low bits must be block aligned.
    assign f_cls   = i_req.free_addr[ADDR_W-1:LOG_POOL];
    assign f_off   = i_req.free_addr[LOG_POOL-1:0];
    assign f_shift = {1'b0, f_cls} + (CLS_W + 1)'(LOG_MIN_BLOCK);
    assign f_mask  = ~({LOG_POOL{1'b1}} << f_shift);
    assign f_bad   = (f_cls >= CLS_W'(NUM_CLASSES)) || ((f_off & f_mask) != '0);

    // Early status known at capture.
    always_comb begin
        d_pre_st = ST_OK;
        if (i_req.cmd == CMD_ALLOC) begin
            if (i_req.req_size == '0) begin
                d_pre_st = ST_ZERO;
            end else if (i_req.req_size
                         > SIZE_W'(class_bytes(CLS_W'(NUM_CLASSES - 1)))) begin
                d_pre_st = ST_LARGE;
            end
        end else if (f_bad) begin
            d_pre_st = ST_BADADDR;
        end
    end

    // Capture the decoded request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_req.cmd;
            r_pre_st <= d_pre_st;
            r_faddr  <= i_req.free_addr;
            r_fidx   <= IDX_W'(f_off >> f_shift);
            if (i_req.cmd == CMD_ALLOC) begin
                r_cls <= a_cls;
            end else if (f_bad) begin
                r_cls <= '0;
            end else begin
                r_cls <= f_cls;
            end
        end
    end

    // Link memory: read the successor of the list head at capture, push on free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_link_rd <= r_link_mem[a_rd_addr];
        end
        if (e_push) begin
            r_link_mem[{r_cls, r_fidx}] <= e_head;
        end
    end

    // Execute: pop, carve or push, and form the result.
    assign e_head      = r_heads[r_cls];
    assign e_fresh     = r_fresh[r_cls];
    assign e_fresh_dec = e_fresh - HEAD_W'(1);
    assign e_bytes     = class_bytes(r_cls);
    assign e_shift     = {1'b0, r_cls} + (CLS_W + 1)'(LOG_MIN_BLOCK);

    always_comb begin
        e_pop   = 1'b0;
        e_carve = 1'b0;
        e_push  = 1'b0;
        e_idx   = '0;
        n_rsp   = '{status:          r_pre_st,
                    block_addr:      '0,
                    size_class:      '0,
                    block_bytes:     '0,
                    allocated_total: r_alloc_total,
                    freed_total:     r_freed_total};
        if (i_cmd.execute && (r_pre_st == ST_OK)) begin
            if (r_op == CMD_ALLOC) begin
                if (e_head != EMPTY_MARK) begin
                    e_pop = 1'b1;
                    e_idx = e_head[IDX_W-1:0];
                end else if (e_fresh != '0) begin
                    e_carve = 1'b1;
                    e_idx   = e_fresh_dec[IDX_W-1:0];
                end
                if (e_pop || e_carve) begin
                    n_rsp.block_addr      = (ADDR_W'(r_cls) << LOG_POOL)
                                          | (ADDR_W'(e_idx) << e_shift);
                    n_rsp.size_class      = r_cls;
                    n_rsp.block_bytes     = e_bytes;
                    n_rsp.allocated_total = r_alloc_total + TOTAL_W'(e_bytes);
                end else begin
                    n_rsp.status     = ST_OOM;
                    n_rsp.size_class = r_cls;
                end
            end else begin
                e_push                = 1'b1;
                n_rsp.block_addr      = r_faddr;
                n_rsp.size_class      = r_cls;
                n_rsp.block_bytes     = e_bytes;
                n_rsp.freed_total     = r_freed_total + TOTAL_W'(e_bytes);
            end
        end
    end

    // List heads, carving counts and byte totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_heads[c] <= EMPTY_MARK;
                r_fresh[c] <= class_blocks(c);
            end
            r_alloc_total <= '0;
            r_freed_total <= '0;
        end else begin
            if (e_pop) begin
                r_heads[r_cls] <= r_link_rd;
            end
            if (e_carve) begin
                r_fresh[r_cls] <= e_fresh_dec;
            end
            if (e_push) begin
                r_heads[r_cls] <= HEAD_W'(r_fidx);
            end
            r_alloc_total <= n_rsp.allocated_total;
            r_freed_total <= n_rsp.freed_total;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== src/size_class_block_allocator_top.sv =====
// Top level of the size-class block allocator.
// Allocates and frees 16, 32, 64, 128 and 256 byte blocks, each class in its own
// 1024 byte region (class c starts at byte offset c * 1024), with one LIFO free
// list per class and fresh blocks carved from the top of the region downward.
// Every request yields exactly one result. A request is handled in a capture step,
// which decodes it and reads the link memory (registered read) at the class's list
// head, and then an execute step, which updates the list head, carving count and
// byte totals and loads the result register. A new request is taken only once the
// last one has loaded its result; a held result blocks the next request only until
// it is taken. The link memory needs no clearing after reset.
module size_class_block_allocator_top
    import scba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_dp_cmd w_cmd;

    // Sequencing and handshakes.
    scba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_cmd       (w_cmd)
    );

    // Free lists, memory and result formation.
    scba_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== src/scba_checker.sv =====
// Port-level checker for the allocator top level and its bind statement.
module scba_checker
    import scba_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // A stalled result holds its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed or dropped");

    // Only one request is in flight: no accept in the cycle after an accept.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while another is in progress");

    // Every accepted request leads to a valid result.
    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |-> ##2 o_rsp_valid)
        else $error("result missing two cycles after request");

    // A successful result reports the block size of its class.
    a_ok_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_OK)
        |-> (o_rsp.block_bytes == class_bytes(o_rsp.size_class)))
        else $error("block size does not match class");

    // A failed result reports no bytes.
    a_err_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_OK) |-> (o_rsp.block_bytes == '0))
        else $error("failed result reports nonzero bytes");

endmodule

bind size_class_block_allocator_top scba_checker u_scba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);

// ===== verif/size_class_block_allocator_top_tb.sv =====
// Self-checking testbench for the size-class block allocator: directed and random requests.
module size_class_block_allocator_top_tb;
    import scba_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int NUM_PHASES       = 4;

    // Tracks allocator state and holds the replies expected for accepted requests.
    class alloc_tracker;
        logic [HEAD_W-1:0]  link_mem [LINK_DEPTH];
        logic [HEAD_W-1:0]  head [NUM_CLASSES];
        logic [HEAD_W-1:0]  carve_left [NUM_CLASSES];
        logic [TOTAL_W-1:0] alloc_sum;
        logic [TOTAL_W-1:0] freed_sum;
        t_rsp               pending_replies[$];
        logic [ADDR_W-1:0]  live_blocks[$];
        int                 fail_count;
        int                 checked;
        int                 status_hits [ST_BADADDR+1];

        function new();
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head[c]       = EMPTY_MARK;
                carve_left[c] = HEAD_W'(MAX_PER_CLASS >> c);
            end
            alloc_sum  = '0;
            freed_sum  = '0;
            fail_count = 0;
            checked    = 0;
            foreach (status_hits[s]) status_hits[s] = 0;
        endfunction

        // Apply an accepted request to the tracked state and queue its reply.
        function void note_request(t_req r);
            t_rsp rsp;
            int   c;
            int   bsz;
            int   idx;
            int   off;
            rsp = '0;
            if (r.cmd == CMD_ALLOC) begin
                if (r.req_size == 0) begin
                    rsp.status = ST_ZERO;
                end else if (int'(r.req_size) > (1 << (LOG_MIN_BLOCK + NUM_CLASSES - 1))) begin
                    rsp.status = ST_LARGE;
                end else begin
                    // Smallest class whose block holds the request.
                    c = 0;
                    while (c < NUM_CLASSES - 1 && (1 << (LOG_MIN_BLOCK + c)) < int'(r.req_size))
                        c++;
                    bsz = 1 << (LOG_MIN_BLOCK + c);
                    idx = -1;
                    if (head[c] != EMPTY_MARK) begin
                        idx     = int'(head[c]);
                        head[c] = link_mem[c * MAX_PER_CLASS + idx];
                    end else if (carve_left[c] != 0) begin
                        carve_left[c] = carve_left[c] - 1'b1;
                        idx           = int'(carve_left[c]);
                    end
                    rsp.size_class = CLS_W'(c);
                    if (idx < 0) begin
                        rsp.status = ST_OOM;
                    end else begin
                        alloc_sum       = alloc_sum + TOTAL_W'(bsz);
                        rsp.status      = ST_OK;
                        rsp.block_addr  = ADDR_W'((c << LOG_POOL) + idx * bsz);
                        rsp.block_bytes = BYTES_W'(bsz);
                        live_blocks.push_back(rsp.block_addr);
                    end
                end
            end else begin
                // Decode class and block index from the byte offset.
                c   = int'(r.free_addr) >> LOG_POOL;
                off = int'(r.free_addr) & ((1 << LOG_POOL) - 1);
                bsz = 1 << (LOG_MIN_BLOCK + c);
                if (c >= NUM_CLASSES || (off % bsz) != 0 || (off / bsz) >= (MAX_PER_CLASS >> c)) begin
                    rsp.status = ST_BADADDR;
                end else begin
                    idx                             = off / bsz;
                    link_mem[c * MAX_PER_CLASS + idx] = head[c];
                    head[c]                         = HEAD_W'(idx);
                    freed_sum                       = freed_sum + TOTAL_W'(bsz);
                    rsp.status                      = ST_OK;
                    rsp.block_addr                  = r.free_addr;
                    rsp.size_class                  = CLS_W'(c);
                    rsp.block_bytes                 = BYTES_W'(bsz);
                    for (int i = 0; i < live_blocks.size(); i++) begin
                        if (live_blocks[i] == r.free_addr) begin
                            live_blocks.delete(i);
                            break;
                        end
                    end
                end
            end
            rsp.allocated_total = alloc_sum;
            rsp.freed_total     = freed_sum;
            pending_replies.push_back(rsp);
        endfunction

        function int field_differs(string name, logic [TOTAL_W-1:0] want,
                                   logic [TOTAL_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                return 1;
            end
            return 0;
        endfunction

        // Compare a delivered reply with the oldest outstanding one.
        function void check_result(t_rsp got);
            t_rsp want;
            if (pending_replies.size() == 0) begin
                $error("reply with no request outstanding: status %0d, block_addr %0d",
                       got.status, got.block_addr);
                fail_count++;
                return;
            end
            want = pending_replies.pop_front();
            checked++;
            if (want.status <= ST_BADADDR) status_hits[want.status]++;
            fail_count += field_differs("status", want.status, got.status);
            fail_count += field_differs("block_addr", want.block_addr, got.block_addr);
            fail_count += field_differs("size_class", want.size_class, got.size_class);
            fail_count += field_differs("block_bytes", want.block_bytes, got.block_bytes);
            fail_count += field_differs("allocated_total", want.allocated_total,
                                        got.allocated_total);
            fail_count += field_differs("freed_total", want.freed_total, got.freed_total);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_req_valid;
    logic         o_req_ready;
    t_req         i_req;
    logic         o_rsp_valid;
    logic         i_rsp_ready;
    t_rsp         o_rsp;

    alloc_tracker tracker;
    int           idle_pct    = 0;
    int           stall_pct   = 0;
    int           cycle_count = 0;
    int           sent        = 0;

    size_class_block_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver with random back-pressure.
    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every reply taken from the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) tracker.check_result(o_rsp);
    end

    function automatic t_req make_req(logic [CMD_W-1:0] cmd, int size, int addr);
        t_req r;
        r.cmd       = cmd;
        r.req_size  = SIZE_W'(size);
        r.free_addr = ADDR_W'(addr);
        return r;
    endfunction

    // Mostly well-formed traffic: sized allocations and frees of live blocks, plus noise.
    function automatic t_req random_req();
        t_req r;
        int   pick;
        int   k;
        int   hi;
        r.cmd       = CMD_ALLOC;
        r.req_size  = SIZE_W'($urandom);
        r.free_addr = ADDR_W'($urandom);
        pick        = $urandom_range(99);
        if (pick < 40 && tracker.live_blocks.size() > 0) begin
            r.cmd       = CMD_FREE;
            r.free_addr = tracker.live_blocks[$urandom_range(tracker.live_blocks.size() - 1)];
        end else if (pick < 84) begin
            k  = $urandom_range(NUM_CLASSES - 1);
            hi = 1 << (LOG_MIN_BLOCK + k);
            if ($urandom_range(3) == 0)
                r.req_size = SIZE_W'(hi);
            else
                r.req_size = SIZE_W'($urandom_range(hi, (k == 0) ? 1 : hi / 2 + 1));
        end else if (pick < 88) begin
            r.req_size = '0;
        end else if (pick < 92) begin
            r.req_size = SIZE_W'($urandom_range(65535, 257));
        end else if (pick < 96) begin
            // Any aligned block of a class, whether allocated or not.
            r.cmd       = CMD_FREE;
            k           = $urandom_range(NUM_CLASSES - 1);
            r.free_addr = ADDR_W'((k << LOG_POOL) +
                          ($urandom_range((MAX_PER_CLASS >> k) - 1) << (LOG_MIN_BLOCK + k)));
        end else begin
            r.cmd = CMD_FREE;
        end
        return r;
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        tracker.note_request(r);
        sent++;
    endtask

    // Hold off new requests until every outstanding reply has arrived.
    task automatic drain_replies();
        i_req_valid <= 1'b0;
        while (tracker.pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence.
    initial begin
        t_req directed[$];
        int   phase_idle  [NUM_PHASES] = '{0, 54, 0, 9};
        int   phase_stall [NUM_PHASES] = '{0, 0, 54, 9};

        tracker     = new();
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_rsp_ready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Errors, every class boundary, exhaustion of the largest class and list reuse.
        directed.push_back(make_req(CMD_ALLOC, 0, 8191));
        directed.push_back(make_req(CMD_ALLOC, 65535, 0));
        directed.push_back(make_req(CMD_ALLOC, 257, 0));
        directed.push_back(make_req(CMD_ALLOC, 1, 0));
        directed.push_back(make_req(CMD_ALLOC, 16, 0));
        directed.push_back(make_req(CMD_ALLOC, 17, 0));
        directed.push_back(make_req(CMD_ALLOC, 32, 0));
        directed.push_back(make_req(CMD_ALLOC, 33, 0));
        directed.push_back(make_req(CMD_ALLOC, 64, 0));
        directed.push_back(make_req(CMD_ALLOC, 65, 0));
        directed.push_back(make_req(CMD_ALLOC, 128, 0));
        directed.push_back(make_req(CMD_ALLOC, 129, 0));
        directed.push_back(make_req(CMD_ALLOC, 256, 0));
        directed.push_back(make_req(CMD_ALLOC, 256, 0));
        directed.push_back(make_req(CMD_ALLOC, 256, 0));
        directed.push_back(make_req(CMD_ALLOC, 256, 0));
        directed.push_back(make_req(CMD_FREE, 65535, 8191));
        directed.push_back(make_req(CMD_FREE, 0, 5120));
        directed.push_back(make_req(CMD_FREE, 0, 5119));
        directed.push_back(make_req(CMD_FREE, 0, 4097));
        directed.push_back(make_req(CMD_FREE, 0, 4864));
        directed.push_back(make_req(CMD_FREE, 0, 0));
        directed.push_back(make_req(CMD_ALLOC, 256, 0));
        directed.push_back(make_req(CMD_ALLOC, 2, 0));
        directed.push_back(make_req(CMD_FREE, 0, 1032));
        foreach (directed[i]) send_req(directed[i]);
        drain_replies();

        // Random traffic under each idling pattern, draining between patterns.
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (RANDOM_PER_PHASE) send_req(random_req());
            drain_replies();
        end

        $display("Sent %0d requests (%0d directed) over %0d idling patterns; %0d replies checked.",
                 sent, directed.size(), NUM_PHASES, tracker.checked);
        $display("Replies: ok %0d, zero size %0d, too large %0d, out of memory %0d, bad address %0d.",
                 tracker.status_hits[ST_OK], tracker.status_hits[ST_ZERO],
                 tracker.status_hits[ST_LARGE], tracker.status_hits[ST_OOM],
                 tracker.status_hits[ST_BADADDR]);
        if (tracker.fail_count == 0 && tracker.pending_replies.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
